// ===== design/lcsa_pkg.sv =====
// lcsa_pkg: shared types, widths and constants of the luma crop/scale address unit.
// Used by lcsa_geom and luma_crop_scale_address_unit. No dependencies.
package lcsa_pkg;

  localparam int unsigned STRIDE_W   = 13;
  localparam int unsigned ROWS_W     = 11;
  localparam int unsigned COORD_W    = 9;
  localparam int unsigned OFFSET_W   = 22;
  localparam int unsigned DIV_W      = 28;
  localparam int unsigned MIN_STRIDE = 6;

  localparam logic [2:0] LUMA_POS [4] = '{3'd1, 3'd3, 3'd4, 3'd5};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_PLAY  = 2'd1,
    ST_NOBUF = 2'd2,
    ST_GEOM  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_STRIDE   = 2'd0,
    REG_ROWS     = 2'd1,
    REG_PLAYBACK = 2'd2,
    REG_BUFFER   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                ready;
    logic [STRIDE_W-1:0] crop_w;
    logic [STRIDE_W-1:0] crop_x;
    logic [ROWS_W-1:0]   crop_h;
    logic [ROWS_W-1:0]   crop_y;
  } geom_t;

endpackage

// ===== design/lcsa_if.sv =====
// lcsa_if: valid/ready channel interfaces for coordinate and address beats.
// Standalone; no package dependency.
interface lcsa_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_x;
  logic [6:0] out_y;
  modport source (output valid, output out_x, output out_y, input ready);
  modport sink (input valid, input out_x, input out_y, output ready);
endinterface

interface lcsa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [21:0] source_offset;
  modport source (output valid, output status, output source_offset, input ready);
  modport sink (input valid, input status, input source_offset, output ready);
endinterface

// ===== design/lcsa_geom.sv =====
// lcsa_geom: works out the crop window from stride and row count; reciprocal multiplies
// for the constant divides, one shared bit-serial divider for the rest. Depends on lcsa_pkg.
module lcsa_geom import lcsa_pkg::*; #(
  parameter int unsigned OUT_WIDTH  = 128,
  parameter int unsigned OUT_HEIGHT = 120
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic [STRIDE_W-1:0] stride_i,
  input  logic [ROWS_W-1:0]   rows_i,
  output geom_t               geom_o
);

  typedef enum logic [2:0] {G_IDLE, G_SRCW, G_H0, G_CW, G_CORR, G_HC, G_FIN} gstate_e;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  // stride / 6 through a reciprocal
  localparam int unsigned     Q6_S = STRIDE_W + $clog2(MIN_STRIDE);
  localparam longint unsigned M6_L = ((64'd1 << Q6_S) + MIN_STRIDE - 1) / MIN_STRIDE;
  localparam int unsigned     M6_W = STRIDE_W + 1;
  localparam logic [M6_W-1:0] M6   = M6_L[M6_W-1:0];
  localparam int unsigned     Q6_P = STRIDE_W + M6_W;

  // src_w * OUT_HEIGHT / OUT_WIDTH, constants folded into one factor
  localparam int unsigned     N_H  = STRIDE_W + $clog2(OUT_HEIGHT);
  localparam int unsigned     S_H  = N_H + $clog2(OUT_WIDTH);
  localparam longint unsigned MH_L = ((64'd1 << S_H) + OUT_WIDTH - 1) / OUT_WIDTH;
  localparam longint unsigned KH_L = MH_L * OUT_HEIGHT;
  localparam int unsigned     KH_W = $clog2(KH_L + 64'd1);
  localparam logic [KH_W-1:0] KH   = KH_L[KH_W-1:0];
  localparam int unsigned     H_P  = STRIDE_W + KH_W;

  // rows * OUT_WIDTH / OUT_HEIGHT, constants folded into one factor
  localparam int unsigned     N_C  = ROWS_W + $clog2(OUT_WIDTH);
  localparam int unsigned     S_C  = N_C + $clog2(OUT_HEIGHT);
  localparam longint unsigned MC_L = ((64'd1 << S_C) + OUT_HEIGHT - 1) / OUT_HEIGHT;
  localparam longint unsigned KC_L = MC_L * OUT_WIDTH;
  localparam int unsigned     KC_W = $clog2(KC_L + 64'd1);
  localparam logic [KC_W-1:0] KC   = KC_L[KC_W-1:0];
  localparam int unsigned     C_P  = ROWS_W + KC_W;

  gstate_e             state_q;
  logic                run_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DIV_W-1:0]    num_q, den_q, rem_q, corr_q;
  logic [STRIDE_W-1:0] src_w_q, crop_w_q, crop_x_q;
  logic [ROWS_W-1:0]   crop_h_q, crop_y_q;

  logic [DIV_W:0]   rem_sh, rem_nx;
  logic             ge;
  logic [DIV_W-1:0] rem_d;
  logic [DIV_W-1:0] src_w_x, crop_w_x, crop_h_x, rows_x;
  logic [DIV_W-1:0] prod_wsq, prod_corr, prod_hc;
  logic [Q6_P-1:0]  q6_prod;
  logic [H_P-1:0]   h_prod, h_quo;
  logic [C_P-1:0]   c_prod, c_quo;

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_q, num_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    rem_d  = rem_nx[DIV_W-1:0];
  end

  always_comb begin
    src_w_x   = DIV_W'(src_w_q);
    crop_w_x  = DIV_W'(crop_w_q);
    crop_h_x  = DIV_W'(crop_h_q);
    rows_x    = DIV_W'(rows_i);
    q6_prod   = Q6_P'(stride_i) * Q6_P'(M6);
    h_prod    = H_P'(src_w_q) * H_P'(KH);
    h_quo     = h_prod >> S_H;
    c_prod    = C_P'(rows_i) * C_P'(KC);
    c_quo     = c_prod >> S_C;
    prod_wsq  = crop_w_x * src_w_x;
    prod_corr = {prod_wsq[DIV_W-2:0], 1'b0} + prod_wsq;
    prod_hc   = crop_h_x * src_w_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= G_SRCW;
      run_q    <= 1'b0;
      cnt_q    <= '0;
      num_q    <= '0;
      den_q    <= '0;
      rem_q    <= '0;
      corr_q   <= '0;
      src_w_q  <= '0;
      crop_w_q <= '0;
      crop_x_q <= '0;
      crop_h_q <= '0;
      crop_y_q <= '0;
    end else if (restart_i) begin
      state_q <= G_SRCW;
      run_q   <= 1'b0;
    end else begin
      if (run_q && cnt_q != '0) begin
        num_q <= {num_q[DIV_W-2:0], ge};
        rem_q <= rem_d;
        cnt_q <= cnt_q - 1'b1;
      end
      unique case (state_q)
        G_IDLE: begin
        end
        G_SRCW: begin
          src_w_q <= {q6_prod[Q6_S +: STRIDE_W-2], 2'b00};
          state_q <= G_H0;
        end
        G_H0: begin
          if (h_quo > H_P'(rows_i)) begin
            crop_h_q <= rows_i;
            state_q  <= G_CW;
          end else begin
            crop_h_q <= h_quo[ROWS_W-1:0];
            crop_w_q <= src_w_q;
            state_q  <= G_CORR;
          end
        end
        G_CW: begin
          crop_w_q <= (c_quo > C_P'(src_w_q)) ? src_w_q : c_quo[STRIDE_W-1:0];
          state_q  <= G_CORR;
        end
        G_CORR: begin
          if (!run_q) begin
            num_q <= prod_corr;
            den_q <= {rows_x[DIV_W-3:0], 2'b00};
            rem_q <= '0;
            cnt_q <= CNT_W'(DIV_W);
            run_q <= 1'b1;
          end else if (cnt_q == '0) begin
            run_q <= 1'b0;
            if (num_q > src_w_x) begin
              corr_q  <= num_q;
              state_q <= G_HC;
            end else begin
              crop_w_q <= num_q[STRIDE_W-1:0];
              state_q  <= G_FIN;
            end
          end
        end
        G_HC: begin
          if (!run_q) begin
            num_q <= prod_hc;
            den_q <= corr_q;
            rem_q <= '0;
            cnt_q <= CNT_W'(DIV_W);
            run_q <= 1'b1;
          end else if (cnt_q == '0) begin
            run_q    <= 1'b0;
            crop_h_q <= num_q[ROWS_W-1:0];
            crop_w_q <= src_w_q;
            state_q  <= G_FIN;
          end
        end
        G_FIN: begin
          crop_x_q <= (src_w_q - crop_w_q) >> 1;
          crop_y_q <= (rows_i - crop_h_q) >> 1;
          state_q  <= G_IDLE;
        end
        default: state_q <= G_SRCW;
      endcase
    end
  end

  assign geom_o.ready  = (state_q == G_IDLE);
  assign geom_o.crop_w = crop_w_q;
  assign geom_o.crop_x = crop_x_q;
  assign geom_o.crop_h = crop_h_q;
  assign geom_o.crop_y = crop_y_q;

endmodule

// ===== design/luma_crop_scale_address_unit.sv =====
// luma_crop_scale_address_unit: top level, five-stage address pipeline.
// Depends on lcsa_pkg, lcsa_if (lcsa_in_if, lcsa_out_if) and lcsa_geom.
//
// Usage:
//   in_s carries one output pixel coordinate (out_x, out_y) per beat; out_m
//   returns one beat per coordinate with a status and the byte offset of the
//   luma sample in the UYVYYY source frame, in the order taken.
//   Configuration goes in through cfg_we_i / cfg_idx_i / cfg_data_i while the
//   unit is idle.
// Throughput:
//   One beat per cycle sustained while out_m.ready is high and the crop window
//   is ready, as every stage advances whenever the stage after it moves.
// Crop window:
//   After reset and after every configuration write the crop window is
//   recomputed: reciprocal steps for the constant divides and up to two
//   bit-serial divides, during which in_s.ready stays low.
// Reset:
//   Registers return to stride 1080, 480 rows, live feed, buffer present;
//   the pipeline empties.
// Stall:
//   When out_m.ready is low the unbroken run of full stages at the output holds
//   its beats, others move up into empty stages; nothing is dropped or repeated.
module luma_crop_scale_address_unit import lcsa_pkg::*; #(
  parameter int unsigned OUT_WIDTH  = 128,
  parameter int unsigned OUT_HEIGHT = 120,
  parameter int unsigned MAX_STRIDE = 4096,
  parameter int unsigned MAX_ROWS   = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcsa_in_if.sink             in_s,
  lcsa_out_if.source          out_m,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [STRIDE_W-1:0] cfg_data_i
);

  // product widths and reciprocal constants for the divides by the plane size
  localparam int unsigned PX_W = COORD_W + STRIDE_W;
  localparam int unsigned PY_W = COORD_W + ROWS_W;
  localparam int unsigned SX   = PX_W + $clog2(OUT_WIDTH);
  localparam int unsigned SY   = PY_W + $clog2(OUT_HEIGHT);
  localparam longint unsigned MX_L = ((64'd1 << SX) + OUT_WIDTH - 1) / OUT_WIDTH;
  localparam longint unsigned MY_L = ((64'd1 << SY) + OUT_HEIGHT - 1) / OUT_HEIGHT;
  localparam logic [PX_W:0] MX = MX_L[PX_W:0];
  localparam logic [PY_W:0] MY = MY_L[PY_W:0];
  localparam logic [COORD_W-1:0]  X_MAX = COORD_W'(OUT_WIDTH - 1);
  localparam logic [COORD_W-1:0]  Y_MAX = COORD_W'(OUT_HEIGHT - 1);
  localparam logic [STRIDE_W-1:0] STRIDE_HI = STRIDE_W'(MAX_STRIDE);
  localparam logic [ROWS_W-1:0]   ROWS_HI   = ROWS_W'(MAX_ROWS);

  // configuration registers
  logic [STRIDE_W-1:0] stride_q;
  logic [ROWS_W-1:0]   rows_q;
  logic                play_q, buf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= STRIDE_W'(1080);
      rows_q   <= ROWS_W'(480);
      play_q   <= 1'b0;
      buf_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_STRIDE:   stride_q <= cfg_data_i;
        REG_ROWS:     rows_q   <= cfg_data_i[ROWS_W-1:0];
        REG_PLAYBACK: play_q   <= cfg_data_i[0];
        REG_BUFFER:   buf_q    <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  geom_t geom;

  lcsa_geom #(
    .OUT_WIDTH  (OUT_WIDTH),
    .OUT_HEIGHT (OUT_HEIGHT)
  ) u_geom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .stride_i  (stride_q),
    .rows_i    (rows_q),
    .geom_o    (geom)
  );

  logic geo_ok;
  assign geo_ok = (stride_q >= STRIDE_W'(MIN_STRIDE)) && (stride_q <= STRIDE_HI) &&
                  (rows_q != '0) && (rows_q <= ROWS_HI);

  // stage valids and advance enables: a stage takes a beat when it is empty or
  // its content moves on
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || out_m.ready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_s.ready = geom.ready && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_s.valid && geom.ready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: saturate the coordinate, resolve the status
  logic [COORD_W-1:0] ox_ext, oy_ext, ox1_q, oy1_q;
  status_e            st_d, st1_q, st2_q, st3_q, st4_q, st5_q;

  always_comb begin
    ox_ext = COORD_W'(in_s.out_x);
    oy_ext = COORD_W'(in_s.out_y);
    priority if (play_q) st_d = ST_PLAY;
    else if (!buf_q)     st_d = ST_NOBUF;
    else if (!geo_ok)    st_d = ST_GEOM;
    else                 st_d = ST_OK;
  end

  // stage 2: scale by the crop size
  logic [PX_W-1:0] px2_q;
  logic [PY_W-1:0] py2_q;

  // stage 3: divide by the plane size through the reciprocal
  logic [2*PX_W:0]       prod_x;
  logic [2*PY_W:0]       prod_y;
  logic [STRIDE_W-1:0]   qx3_q;
  logic [ROWS_W-1:0]     qy3_q;

  always_comb begin
    prod_x = (2*PX_W+1)'(px2_q) * (2*PX_W+1)'(MX);
    prod_y = (2*PY_W+1)'(py2_q) * (2*PY_W+1)'(MY);
  end

  // stage 4: place in the crop, map to the luma byte, clamp to the row end
  logic [STRIDE_W:0]   sx_sum;
  logic [STRIDE_W-1:0] sx;
  logic [STRIDE_W:0]   col_raw;
  logic [STRIDE_W-1:0] col_d, col4_q;
  logic [ROWS_W:0]     row_sum;
  logic [ROWS_W-1:0]   row4_q;

  always_comb begin
    sx_sum  = {1'b0, geom.crop_x} + {1'b0, qx3_q};
    sx      = sx_sum[STRIDE_W-1:0];
    col_raw = {1'b0, sx[STRIDE_W-1:2], 2'b00} + {2'b00, sx[STRIDE_W-1:2], 1'b0}
              + (STRIDE_W+1)'(LUMA_POS[sx[1:0]]);
    col_d   = (col_raw >= {1'b0, stride_q}) ? (stride_q - 1'b1) : col_raw[STRIDE_W-1:0];
    row_sum = {1'b0, geom.crop_y} + {1'b0, qy3_q};
  end

  // stage 5: row times stride plus column; zero on any error
  logic [ROWS_W+STRIDE_W:0] off_full;
  logic [OFFSET_W-1:0]      off5_q;

  always_comb begin
    off_full = (ROWS_W+STRIDE_W+1)'(row4_q) * (ROWS_W+STRIDE_W+1)'(stride_q)
               + (ROWS_W+STRIDE_W+1)'(col4_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ox1_q <= (ox_ext > X_MAX) ? X_MAX : ox_ext;
      oy1_q <= (oy_ext > Y_MAX) ? Y_MAX : oy_ext;
      st1_q <= st_d;
    end
    if (en2) begin
      px2_q <= PX_W'(ox1_q) * PX_W'(geom.crop_w);
      py2_q <= PY_W'(oy1_q) * PY_W'(geom.crop_h);
      st2_q <= st1_q;
    end
    if (en3) begin
      qx3_q <= prod_x[SX +: STRIDE_W];
      qy3_q <= prod_y[SY +: ROWS_W];
      st3_q <= st2_q;
    end
    if (en4) begin
      col4_q <= col_d;
      row4_q <= row_sum[ROWS_W-1:0];
      st4_q  <= st3_q;
    end
    if (en5) begin
      off5_q <= (st4_q == ST_OK) ? off_full[OFFSET_W-1:0] : '0;
      st5_q  <= st4_q;
    end
  end

  assign out_m.valid         = v5_q;
  assign out_m.status        = st5_q;
  assign out_m.source_offset = off5_q;

endmodule
